>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/twpl_pkg.sv
// ----------------------------------------------------------------------------
// twpl_pkg
// shared widths, codes and types of the time window pair lister
// ----------------------------------------------------------------------------
package twpl_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ROW_W       = 6;
    localparam int CMP_W       = (CNT_W > ROW_W) ? CNT_W : ROW_W;
    localparam int TIME_W      = 63;
    localparam int DET_W       = 4;
    localparam int LAG_W       = 48;
    localparam int MODE_W      = 2;
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int RESULT_CAP  = 63;
    localparam int NMATCH_W    = $clog2(RESULT_CAP + 1);

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SAME = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIFF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ANY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MODE = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_LAT,
        ST_COL_RD,
        ST_DIFF,
        ST_TEST,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] rec_time;
        logic [DET_W-1:0]  rec_det;
    } t_rec;

    typedef struct packed {
        logic [LAG_W-1:0]  max_lag;
        logic [MODE_W-1:0] pair_mode;
    } t_cfg;

endpackage

>>> hw/rtl/twpl_match.sv
// ----------------------------------------------------------------------------
// twpl_match
// shared pair test: registered absolute time difference and detector rule,
// then lag compare
// ----------------------------------------------------------------------------
module twpl_match (
    input  logic             i_clk,
    input  logic             i_load,
    input  twpl_pkg::t_rec   i_row_rec,
    input  twpl_pkg::t_rec   i_col_rec,
    input  twpl_pkg::t_cfg   i_cfg,
    output logic             o_match
);

    logic [twpl_pkg::TIME_W:0]   diff_ab;
    logic [twpl_pkg::TIME_W:0]   diff_ba;
    logic [twpl_pkg::TIME_W-1:0] n_abs_diff;
    logic [twpl_pkg::TIME_W-1:0] r_abs_diff;
    logic                        n_det_ok;
    logic                        r_det_ok;
    logic                        det_eq;

    assign diff_ab = {1'b0, i_row_rec.rec_time} - {1'b0, i_col_rec.rec_time};
    assign diff_ba = {1'b0, i_col_rec.rec_time} - {1'b0, i_row_rec.rec_time};
    assign det_eq  = (i_row_rec.rec_det == i_col_rec.rec_det);

    always_comb begin
        n_abs_diff = diff_ab[twpl_pkg::TIME_W] ? diff_ba[twpl_pkg::TIME_W-1:0]
                                               : diff_ab[twpl_pkg::TIME_W-1:0];
        case (i_cfg.pair_mode)
            twpl_pkg::MODE_SAME: n_det_ok = det_eq;
            twpl_pkg::MODE_DIFF: n_det_ok = !det_eq;
            twpl_pkg::MODE_ANY:  n_det_ok = 1'b1;
            default:             n_det_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_abs_diff <= n_abs_diff;
            r_det_ok   <= n_det_ok;
        end
    end

    assign o_match = r_det_ok &&
                     (r_abs_diff <= twpl_pkg::TIME_W'(i_cfg.max_lag));

endmodule

>>> hw/rtl/time_window_pair_lister.sv
// ----------------------------------------------------------------------------
// time_window_pair_lister
// record table with row queries listing time-coincident index pairs
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries requests: append a record,
// query a row, or clear the table. Output channel (o_out_valid / i_out_ready)
// carries one transaction per listed pair (first, second index), the last one
// flagged; a query with no match or an out-of-range row gives one empty
// marker with last set. Append and clear give no output. A row query reads
// the row record (states ROW_RD, ROW_LAT), then tests each later index j
// through a single registered difference/compare unit (states COL_RD, DIFF,
// TEST for each j). The next request is taken only when the query is done.
// One pending match is held back so the last pair can be flagged; when the
// receiver stalls, the scan waits on the output register. Synchronous
// active-low reset empties the table, drops any output, sets max_lag to 0
// and pair_mode to any. Table contents need no clearing pass: only entries
// below the record count are ever read. Configuration writes (i_cfg_wr_en)
// are taken any cycle and used by a query in progress too; the user is to
// write them only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module time_window_pair_lister (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [twpl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [twpl_pkg::LAG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [twpl_pkg::REQ_W-1:0]        i_req_type,
    input  logic [twpl_pkg::TIME_W-1:0]       i_record_time,
    input  logic [twpl_pkg::DET_W-1:0]        i_detector_id,
    input  logic [twpl_pkg::ROW_W-1:0]        i_row_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [twpl_pkg::ROW_W-1:0]        o_first_index,
    output logic [twpl_pkg::ROW_W-1:0]        o_second_index,
    output logic                              o_pair_valid,
    output logic                              o_last_pair
);

    twpl_pkg::t_state                r_state, n_state;
    logic [twpl_pkg::CNT_W-1:0]      r_count, n_count;
    logic [twpl_pkg::IDX_W-1:0]      r_rd_addr, n_rd_addr;
    logic [twpl_pkg::ROW_W-1:0]      r_row, n_row;
    logic [twpl_pkg::IDX_W-1:0]      r_pend, n_pend;
    logic                            r_have_pend, n_have_pend;
    logic [twpl_pkg::NMATCH_W-1:0]   r_nmatch, n_nmatch;
    twpl_pkg::t_rec                  r_row_rec, n_row_rec;
    twpl_pkg::t_cfg                  r_cfg;
    logic                            r_out_valid, n_out_valid;
    logic [twpl_pkg::ROW_W-1:0]      r_out_first, n_out_first;
    logic [twpl_pkg::ROW_W-1:0]      r_out_second, n_out_second;
    logic                            r_out_pvalid, n_out_pvalid;
    logic                            r_out_last, n_out_last;

    twpl_pkg::t_rec                  r_mem [twpl_pkg::MAX_ENTRIES];
    twpl_pkg::t_rec                  r_rd_data;
    twpl_pkg::t_rec                  wr_rec;
    logic                            mem_we;
    logic                            mu_load;
    logic                            match;
    logic                            in_take;
    logic                            out_free;
    logic                            done;
    logic [twpl_pkg::CNT_W-1:0]      nxt_col;

    assign o_in_ready     = (r_state == twpl_pkg::ST_IDLE);
    assign in_take        = i_in_valid && o_in_ready;
    assign out_free       = !r_out_valid;
    assign nxt_col        = twpl_pkg::CNT_W'(r_rd_addr) + twpl_pkg::CNT_W'(1);
    assign wr_rec         = '{rec_time: i_record_time, rec_det: i_detector_id};

    assign o_out_valid    = r_out_valid;
    assign o_first_index  = r_out_first;
    assign o_second_index = r_out_second;
    assign o_pair_valid   = r_out_pvalid;
    assign o_last_pair    = r_out_last;

    twpl_match u_match (
        .i_clk     (i_clk),
        .i_load    (mu_load),
        .i_row_rec (r_row_rec),
        .i_col_rec (r_rd_data),
        .i_cfg     (r_cfg),
        .o_match   (match)
    );

    // record table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[twpl_pkg::IDX_W-1:0]] <= wr_rec;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_addr    = r_rd_addr;
        n_row        = r_row;
        n_pend       = r_pend;
        n_have_pend  = r_have_pend;
        n_nmatch     = r_nmatch;
        n_row_rec    = r_row_rec;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_pvalid = r_out_pvalid;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mu_load      = 1'b0;
        done         = 1'b0;

        unique case (r_state)
            twpl_pkg::ST_IDLE: begin
                if (in_take) begin
                    case (i_req_type)
                        twpl_pkg::REQ_APPEND: begin
                            if (r_count < twpl_pkg::CNT_W'(twpl_pkg::MAX_ENTRIES)) begin
                                mem_we  = 1'b1;
                                n_count = r_count + twpl_pkg::CNT_W'(1);
                            end
                        end
                        twpl_pkg::REQ_CLEAR: begin
                            n_count = '0;
                        end
                        twpl_pkg::REQ_QUERY: begin
                            n_row       = i_row_index;
                            n_nmatch    = '0;
                            n_have_pend = 1'b0;
                            if (twpl_pkg::CMP_W'(i_row_index) < twpl_pkg::CMP_W'(r_count)) begin
                                n_rd_addr = twpl_pkg::IDX_W'(i_row_index);
                                n_state   = twpl_pkg::ST_ROW_RD;
                            end else begin
                                n_state   = twpl_pkg::ST_FIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            twpl_pkg::ST_ROW_RD: begin
                n_state = twpl_pkg::ST_ROW_LAT;
            end
            twpl_pkg::ST_ROW_LAT: begin
                n_row_rec = r_rd_data;
                if (nxt_col < r_count) begin
                    n_rd_addr = nxt_col[twpl_pkg::IDX_W-1:0];
                    n_state   = twpl_pkg::ST_COL_RD;
                end else begin
                    n_state   = twpl_pkg::ST_FIN;
                end
            end
            twpl_pkg::ST_COL_RD: begin
                n_state = twpl_pkg::ST_DIFF;
            end
            twpl_pkg::ST_DIFF: begin
                mu_load = 1'b1;
                n_state = twpl_pkg::ST_TEST;
            end
            twpl_pkg::ST_TEST: begin
                done = !(nxt_col < r_count) ||
                       (match &&
                        (r_nmatch == twpl_pkg::NMATCH_W'(twpl_pkg::RESULT_CAP - 1)));
                if (!(match && r_have_pend && !out_free)) begin
                    if (match) begin
                        if (r_have_pend) begin
                            n_out_valid  = 1'b1;
                            n_out_first  = r_row;
                            n_out_second = twpl_pkg::ROW_W'(r_pend);
                            n_out_pvalid = 1'b1;
                            n_out_last   = 1'b0;
                        end
                        n_pend      = r_rd_addr;
                        n_have_pend = 1'b1;
                        n_nmatch    = r_nmatch + twpl_pkg::NMATCH_W'(1);
                    end
                    if (done) begin
                        n_state   = twpl_pkg::ST_FIN;
                    end else begin
                        n_rd_addr = nxt_col[twpl_pkg::IDX_W-1:0];
                        n_state   = twpl_pkg::ST_COL_RD;
                    end
                end
            end
            twpl_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_first  = r_row;
                    n_out_second = r_have_pend ? twpl_pkg::ROW_W'(r_pend) : '0;
                    n_out_pvalid = r_have_pend;
                    n_out_last   = 1'b1;
                    n_state      = twpl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = twpl_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= twpl_pkg::ST_IDLE;
            r_count           <= '0;
            r_out_valid       <= 1'b0;
            r_cfg.max_lag     <= '0;
            r_cfg.pair_mode   <= twpl_pkg::MODE_ANY;
        end else begin
            r_state           <= n_state;
            r_count           <= n_count;
            r_out_valid       <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    twpl_pkg::CFG_MAX_LAG:   r_cfg.max_lag   <= i_cfg_data;
                    twpl_pkg::CFG_PAIR_MODE: r_cfg.pair_mode <= i_cfg_data[twpl_pkg::MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_addr    <= n_rd_addr;
        r_row        <= n_row;
        r_pend       <= n_pend;
        r_have_pend  <= n_have_pend;
        r_nmatch     <= n_nmatch;
        r_row_rec    <= n_row_rec;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_pvalid <= n_out_pvalid;
        r_out_last   <= n_out_last;
    end

endmodule

>>> hw/rtl/twpl_checker.sv
// ----------------------------------------------------------------------------
// twpl_checker
// port-level checks of the time window pair lister, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twpl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic [twpl_pkg::REQ_W-1:0]        i_req_type,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic [twpl_pkg::ROW_W-1:0]        o_first_index,
    input  logic [twpl_pkg::ROW_W-1:0]        o_second_index,
    input  logic                              o_pair_valid,
    input  logic                              o_last_pair
);

    // stalled output transaction holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_first_index) && $stable(o_second_index) && $stable(o_pair_valid) && $stable(o_last_pair))

    // empty marker always closes its query
    `ASSERT_IMPL(a_empty_last, i_clk, i_rst_n, o_out_valid && !o_pair_valid, o_last_pair)

    // a real pair lists a later index
    `ASSERT_IMPL(a_pair_order, i_clk, i_rst_n, o_out_valid && o_pair_valid, o_second_index > o_first_index)

    // a query holds off the next request
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_req_type == twpl_pkg::REQ_QUERY), !o_in_ready)

endmodule

bind time_window_pair_lister twpl_checker u_twpl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_req_type     (i_req_type),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_first_index  (o_first_index),
    .o_second_index (o_second_index),
    .o_pair_valid   (o_pair_valid),
    .o_last_pair    (o_last_pair)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the time window pair lister: records are appended,
// rows are queried and every listed pair is predicted and compared in order
// under random idle gaps on the request side and random stalls on the results
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [twpl_pkg::REQ_W-1:0]  REQ_UNUSED  = 2'd3;
    localparam logic [twpl_pkg::MODE_W-1:0] MODE_NONE   = 2'd3;
    localparam logic [twpl_pkg::TIME_W-1:0] TIME_MAX    = '1;
    localparam logic [twpl_pkg::LAG_W-1:0]  LAG_MAX     = '1;
    localparam int                          CYCLE_LIMIT = 1_000_000;
    localparam int                          HOLD_CYCLES = 400;

    typedef struct packed {
        logic [twpl_pkg::ROW_W-1:0] first_idx;
        logic [twpl_pkg::ROW_W-1:0] second_idx;
        logic                       is_pair;
        logic                       is_last;
    } t_pair_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [twpl_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [twpl_pkg::LAG_W-1:0]     i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [twpl_pkg::REQ_W-1:0]     i_req_type;
    logic [twpl_pkg::TIME_W-1:0]    i_record_time;
    logic [twpl_pkg::DET_W-1:0]     i_detector_id;
    logic [twpl_pkg::ROW_W-1:0]     i_row_index;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [twpl_pkg::ROW_W-1:0]     o_first_index;
    logic [twpl_pkg::ROW_W-1:0]     o_second_index;
    logic                           o_pair_valid;
    logic                           o_last_pair;

    // predictor state
    logic [twpl_pkg::TIME_W-1:0] stamp_tbl [twpl_pkg::MAX_ENTRIES];
    logic [twpl_pkg::DET_W-1:0]  det_tbl [twpl_pkg::MAX_ENTRIES];
    int                          rec_count = 0;
    logic [twpl_pkg::LAG_W-1:0]  lag_reg = '0;
    logic [twpl_pkg::MODE_W-1:0] mode_reg = twpl_pkg::MODE_ANY;

    t_pair_result pending_pairs [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           out_hold = 0;
    int           out_wait = 0;
    bit           gaps_on = 1'b1;

    time_window_pair_lister i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_record_time  (i_record_time),
        .i_detector_id  (i_detector_id),
        .i_row_index    (i_row_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_first_index  (o_first_index),
        .o_second_index (o_second_index),
        .o_pair_valid   (o_pair_valid),
        .o_last_pair    (o_last_pair)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [twpl_pkg::TIME_W-1:0] rand_stamp();
        return twpl_pkg::TIME_W'(rand64());
    endfunction

    function automatic bit detectors_agree(logic [twpl_pkg::DET_W-1:0] a,
                                           logic [twpl_pkg::DET_W-1:0] b);
        if (mode_reg == twpl_pkg::MODE_ANY) return 1'b1;
        return ((a != b) ? twpl_pkg::MODE_DIFF : twpl_pkg::MODE_SAME) == mode_reg;
    endfunction

    task automatic list_row_pairs(logic [twpl_pkg::ROW_W-1:0] row);
        int                          hits [$];
        logic [twpl_pkg::TIME_W-1:0] span_ns;
        t_pair_result                r;
        if (row < rec_count) begin
            for (int j = row + 1; j < rec_count && hits.size() < twpl_pkg::RESULT_CAP; j++)
            begin
                span_ns = (stamp_tbl[row] >= stamp_tbl[j]) ? stamp_tbl[row] - stamp_tbl[j]
                                                            : stamp_tbl[j] - stamp_tbl[row];
                if (detectors_agree(det_tbl[row], det_tbl[j]) && span_ns <= lag_reg)
                    hits.push_back(j);
            end
        end
        if (hits.size() == 0) begin
            r = '{first_idx: row, second_idx: '0, is_pair: 1'b0, is_last: 1'b1};
            pending_pairs.push_back(r);
        end else begin
            foreach (hits[k]) begin
                r = '{first_idx: row, second_idx: twpl_pkg::ROW_W'(hits[k]), is_pair: 1'b1,
                      is_last: (k == hits.size() - 1)};
                pending_pairs.push_back(r);
            end
        end
    endtask

    task automatic predict_request(logic [twpl_pkg::REQ_W-1:0] kind,
                                   logic [twpl_pkg::TIME_W-1:0] stamp,
                                   logic [twpl_pkg::DET_W-1:0] det,
                                   logic [twpl_pkg::ROW_W-1:0] row);
        case (kind)
            twpl_pkg::REQ_APPEND: begin
                if (rec_count < twpl_pkg::MAX_ENTRIES) begin
                    stamp_tbl[rec_count] = stamp;
                    det_tbl[rec_count]   = det;
                    rec_count++;
                end
            end
            twpl_pkg::REQ_CLEAR: rec_count = 0;
            twpl_pkg::REQ_QUERY: list_row_pairs(row);
            default: ;
        endcase
    endtask

    task automatic send_request(logic [twpl_pkg::REQ_W-1:0] kind,
                                logic [twpl_pkg::TIME_W-1:0] stamp,
                                logic [twpl_pkg::DET_W-1:0] det,
                                logic [twpl_pkg::ROW_W-1:0] row);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type    = kind;
        i_record_time = stamp;
        i_detector_id = det;
        i_row_index   = row;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(kind, stamp, det, row);
    endtask

    task automatic append_record(logic [twpl_pkg::TIME_W-1:0] stamp,
                                 logic [twpl_pkg::DET_W-1:0] det);
        send_request(twpl_pkg::REQ_APPEND, stamp, det, twpl_pkg::ROW_W'($urandom));
    endtask

    task automatic query_row(logic [twpl_pkg::ROW_W-1:0] row);
        send_request(twpl_pkg::REQ_QUERY, rand_stamp(), twpl_pkg::DET_W'($urandom), row);
    endtask

    task automatic clear_table();
        send_request(twpl_pkg::REQ_CLEAR, rand_stamp(), twpl_pkg::DET_W'($urandom),
                     twpl_pkg::ROW_W'($urandom));
    endtask

    // no transaction pending and the block back in idle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pairs.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [twpl_pkg::CFG_IDX_W-1:0] idx,
                             logic [twpl_pkg::LAG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (idx == twpl_pkg::CFG_MAX_LAG) lag_reg = data;
        else mode_reg = data[twpl_pkg::MODE_W-1:0];
    endtask

    task automatic write_mode(logic [twpl_pkg::MODE_W-1:0] mode);
        logic [twpl_pkg::LAG_W-1:0] data;
        data = twpl_pkg::LAG_W'(rand64());
        data[twpl_pkg::MODE_W-1:0] = mode;
        write_reg(twpl_pkg::CFG_PAIR_MODE, data);
    endtask

    // timestamps around base, biased to the lag boundary
    function automatic logic [twpl_pkg::TIME_W-1:0] draw_stamp(
        logic [twpl_pkg::TIME_W-1:0] base);
        logic [63:0] span;
        logic [63:0] offset;
        case ($urandom_range(0, 7))
            0: return rand_stamp();
            1: return base + lag_reg;
            2: return base - lag_reg - 1;
            default: begin
                span   = {16'b0, lag_reg} + 64'd2;
                offset = rand64() % span;
                return twpl_pkg::TIME_W'($urandom_range(0, 1) ? base + offset
                                                              : base - offset);
            end
        endcase
    endfunction

    task automatic test_edge_cases();
        write_reg(twpl_pkg::CFG_MAX_LAG, 48'd10);
        write_mode(twpl_pkg::MODE_ANY);
        clear_table();
        query_row(6'd0);
        append_record(TIME_MAX, 4'hF);
        append_record(TIME_MAX - 10, 4'hF);
        append_record(TIME_MAX - 11, 4'h0);
        append_record('0, 4'h0);
        query_row(6'd0);
        query_row(6'd1);
        query_row(6'd2);
        query_row(6'd3);
        query_row(6'd4);
        query_row(6'd63);
        send_request(REQ_UNUSED, rand_stamp(), twpl_pkg::DET_W'($urandom), 6'd0);
        wait_idle();
        write_mode(twpl_pkg::MODE_SAME);
        query_row(6'd0);
        query_row(6'd1);
        wait_idle();
        write_mode(twpl_pkg::MODE_DIFF);
        query_row(6'd0);
        query_row(6'd1);
        wait_idle();
        write_mode(MODE_NONE);
        query_row(6'd0);
        wait_idle();
        write_reg(twpl_pkg::CFG_MAX_LAG, LAG_MAX);
        write_mode(twpl_pkg::MODE_ANY);
        append_record(twpl_pkg::TIME_W'(LAG_MAX), 4'h3);
        append_record(twpl_pkg::TIME_W'(LAG_MAX) + 1, 4'h3);
        query_row(6'd3);
    endtask

    task automatic test_backpressure();
        logic [twpl_pkg::TIME_W-1:0] base;
        wait_idle();
        write_reg(twpl_pkg::CFG_MAX_LAG, LAG_MAX);
        write_mode(twpl_pkg::MODE_ANY);
        gaps_on = 1'b0;
        base = twpl_pkg::TIME_W'(rand64() >> 2);
        clear_table();
        // one more than the table holds, the last one is dropped
        for (int k = 0; k <= twpl_pkg::MAX_ENTRIES; k++)
            append_record(base + $urandom_range(0, 1000000), twpl_pkg::DET_W'($urandom));
        out_hold = HOLD_CYCLES;
        query_row(6'd0);
        query_row(6'd1);
        query_row(6'd62);
        query_row(6'd63);
        wait_idle();
        gaps_on = 1'b1;
        query_row(6'd0);
    endtask

    task automatic test_random_windows();
        logic [twpl_pkg::LAG_W-1:0]  lag;
        logic [twpl_pkg::TIME_W-1:0] base;
        logic [twpl_pkg::MODE_W-1:0] mode;
        logic [twpl_pkg::DET_W-1:0]  det;
        int                          lag_pick;
        int                          size;
        int                          det_pool;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            gaps_on  = (phase % 3 != 2);
            lag_pick = (phase < 4) ? phase : $urandom_range(0, 3);
            case (lag_pick)
                0: lag = '0;
                1: lag = LAG_MAX;
                2: lag = twpl_pkg::LAG_W'($urandom_range(1, 1000));
                default: lag = twpl_pkg::LAG_W'(rand64());
            endcase
            mode = (phase < 4) ? twpl_pkg::MODE_W'(3 - phase)
                               : twpl_pkg::MODE_W'($urandom_range(0, 2));
            write_reg(twpl_pkg::CFG_MAX_LAG, lag);
            write_mode(mode);
            for (int seq = 0; seq < 2; seq++) begin
                clear_table();
                size     = ($urandom_range(0, 9) == 0)
                           ? $urandom_range(20, twpl_pkg::MAX_ENTRIES)
                           : $urandom_range(1, 8);
                base     = rand_stamp();
                det_pool = $urandom_range(0, 14);
                for (int k = 0; k < size; k++) begin
                    det = ($urandom_range(0, 3) == 0)
                          ? twpl_pkg::DET_W'($urandom)
                          : twpl_pkg::DET_W'(det_pool + $urandom_range(0, 1));
                    append_record(draw_stamp(base), det);
                end
                if (size == twpl_pkg::MAX_ENTRIES)
                    append_record(rand_stamp(), twpl_pkg::DET_W'($urandom));
                if (size > 16) begin
                    for (int k = 0; k < 6; k++)
                        query_row(twpl_pkg::ROW_W'($urandom_range(0, size - 1)));
                end else begin
                    for (int row = 0; row < size; row++) query_row(twpl_pkg::ROW_W'(row));
                end
                case ($urandom_range(0, 3))
                    0: query_row(twpl_pkg::ROW_W'($urandom_range(0, 63)));
                    1: send_request(REQ_UNUSED, rand_stamp(), twpl_pkg::DET_W'($urandom),
                                    twpl_pkg::ROW_W'($urandom));
                    2: begin
                        append_record(draw_stamp(base), twpl_pkg::DET_W'($urandom));
                        query_row(twpl_pkg::ROW_W'($urandom_range(0, size)));
                    end
                    default: ;
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_req_type    = twpl_pkg::REQ_APPEND;
        i_record_time = '0;
        i_detector_id = '0;
        i_row_index   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_cases();
        test_backpressure();
        test_random_windows();

        wait_idle();
        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0 && pending_pairs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // result side stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold > 0) begin
                out_hold--;
                i_out_ready = 1'b0;
            end else if (out_wait > 0) begin
                out_wait--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_pair_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d %0d",
                         $time, o_first_index, o_second_index, o_pair_valid, o_last_pair);
                mismatch_count++;
            end else begin
                want = pending_pairs.pop_front();
                check_field("first_index", int'(want.first_idx), int'(o_first_index));
                check_field("second_index", int'(want.second_idx), int'(o_second_index));
                check_field("pair_valid", int'(want.is_pair), int'(o_pair_valid));
                check_field("last_pair", int'(want.is_last), int'(o_last_pair));
            end
            out_wait = gaps_on ? $urandom_range(0, 15) : 0;
        end
    end

endmodule
